[hw/rtl/prd_pkg.sv]
// Package for the pulse rate detector: shared widths, constants, register
// indexes and state types. No dependencies; imported by every module of the block.
package prd_pkg;

  // Configuration register widths and reset values.
  localparam int LEVEL_CFG_W  = 12;
  localparam int PERIOD_W     = 24;
  localparam int WEIGHT_W     = 16;
  localparam int FRAC_W       = 8;

  localparam logic [LEVEL_CFG_W-1:0] BASELINE_START_RST = 12'd2000;
  localparam logic [LEVEL_CFG_W-1:0] RISE_MARGIN_RST    = 12'd250;
  localparam logic [PERIOD_W-1:0]    REPORT_PERIOD_RST  = 24'd500000;
  localparam logic [WEIGHT_W-1:0]    BASELINE_WEIGHT_RST = 16'd3277;
  localparam logic [WEIGHT_W-1:0]    RATE_WEIGHT_RST     = 16'd13107;

  // Register indexes on the configuration port (byte address / 4).
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_MARGIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_WEIGHT     = 3'd4;

  // Rate arithmetic: Q16.8 beats per minute, 60e6 us/min scaled by 256.
  localparam int RATE_W     = 24;
  localparam int RATE_NUM_W = 34;
  localparam logic [RATE_NUM_W-1:0] RATE_NUMERATOR = 34'd15360000000;
  localparam logic [RATE_W-1:0]     RATE_MAX       = 24'hFFFFFF;
  localparam int BPM_W      = 16;

  // Exponential blend: products are Q.16, rounded at bit 15.
  localparam int BLEND_SHIFT = 16;

  // Top-level sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE_MUL0,
    S_BASE_MUL1,
    S_BASE_UPD,
    S_DETECT,
    S_DIV_WAIT,
    S_RATE_MUL0,
    S_RATE_MUL1,
    S_RATE_UPD,
    S_REPORT
  } prd_state_t;

  // Divider states.
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_STEP
  } prd_div_state_t;

endpackage

[hw/rtl/prd_rate_div.sv]
// Beat-rate divider: rounded 15,360,000,000 / interval, saturated to 24 bits.
// One quotient bit per cycle after a single saturation check. Uses prd_pkg.
module prd_rate_div #(
  parameter int TIME_BITS = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [TIME_BITS-1:0]        divisor,
  output logic                        done,
  output logic [prd_pkg::RATE_W-1:0]  quotient
);
  import prd_pkg::*;

  localparam int NUM_W = ((TIME_BITS > RATE_NUM_W) ? TIME_BITS : RATE_NUM_W) + 1;
  localparam int CMP_W = TIME_BITS + RATE_W + 1;
  localparam int CNT_W = $clog2(RATE_W + 1);

  prd_div_state_t state, state_next;

  logic [TIME_BITS-1:0] divisor_q;
  logic [NUM_W-1:0]     numer;
  logic [TIME_BITS-1:0] rem;
  logic [RATE_W-1:0]    low_bits;
  logic [CNT_W-1:0]     cnt;

  logic                 sat;
  logic [TIME_BITS:0]   partial;
  logic [TIME_BITS:0]   diff;
  logic                 ge;
  logic                 last_step;

  // A quotient of 2^24 or more means the rate saturates; otherwise the upper
  // numerator bits already sit below the divisor and 24 steps finish the job.
  assign sat       = CMP_W'(numer) >= {1'b0, divisor_q, {RATE_W{1'b0}}};
  assign partial   = {rem, low_bits[RATE_W-1]};
  assign ge        = partial >= {1'b0, divisor_q};
  assign diff      = partial - {1'b0, divisor_q};
  assign last_step = (cnt == CNT_W'(1));

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      DV_IDLE: begin
        if (start) state_next = DV_CHECK;
      end
      DV_CHECK: begin
        state_next = sat ? DV_IDLE : DV_STEP;
      end
      DV_STEP: begin
        if (last_step) state_next = DV_IDLE;
      end
      default: state_next = DV_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == DV_CHECK) && sat) || ((state == DV_STEP) && last_step);
    end
  end

  // Restoring division datapath.
  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          divisor_q <= divisor;
          numer     <= NUM_W'(RATE_NUMERATOR) + NUM_W'(divisor >> 1);
        end
      end
      DV_CHECK: begin
        if (sat) begin
          quotient <= RATE_MAX;
        end else begin
          quotient <= '0;
          rem      <= TIME_BITS'(numer >> RATE_W);
          low_bits <= numer[RATE_W-1:0];
          cnt      <= CNT_W'(RATE_W);
        end
      end
      DV_STEP: begin
        rem      <= ge ? diff[TIME_BITS-1:0] : partial[TIME_BITS-1:0];
        quotient <= {quotient[RATE_W-2:0], ge};
        low_bits <= low_bits << 1;
        cnt      <= cnt - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/pulse_rate_detector.sv]
// Pulse rate detector top level: sequencer, shared multiply-accumulate unit,
// configuration registers and output register. Uses prd_pkg and prd_rate_div.
//
//   Channel   Signals                                   Direction
//   in        in_valid, in_stall, sample_value,         sample in
//             sample_time_us
//   out       out_valid, out_stall, rate_bpm,           rate report out
//             pulse_active
//   config    psel, penable, pwrite, paddr, pwdata,     register access
//             prdata, pready
//
// An input transaction occupies the block through the baseline blend, detection
// and report states; a pulse start that needs a new rate adds the divider, whose
// 24 one-bit steps are skipped if its first check saturates, and the rate blend.
// All blend products go through one 24x17 multiplier with an accumulator.
// A report waits in the sequencer only while the output register is full and out_stall is high.
// Reset is synchronous and restores the configuration and detector state.
module pulse_rate_detector #(
  parameter int SAMPLE_BITS = 12,
  parameter int TIME_BITS   = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  input  logic [TIME_BITS-1:0]   sample_time_us,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [prd_pkg::BPM_W-1:0] rate_bpm,
  output logic                   pulse_active,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import prd_pkg::*;

  localparam int LVL_W   = ((SAMPLE_BITS > LEVEL_CFG_W) ? SAMPLE_BITS : LEVEL_CFG_W) + FRAC_W;
  localparam int MUL_A_W = (LVL_W > RATE_W) ? LVL_W : RATE_W;
  localparam int MUL_B_W = WEIGHT_W + 1;
  localparam int ACC_W   = MUL_A_W + MUL_B_W;

  prd_state_t state, state_next;

  // Configuration registers.
  logic [LEVEL_CFG_W-1:0] baseline_start;
  logic [LEVEL_CFG_W-1:0] rise_margin;
  logic [PERIOD_W-1:0]    report_period_us;
  logic [WEIGHT_W-1:0]    baseline_weight;
  logic [WEIGHT_W-1:0]    rate_weight;

  // Detector state.
  logic [LVL_W-1:0]     baseline_level;
  logic                 in_pulse;
  logic                 have_prior_pulse;
  logic [TIME_BITS-1:0] prior_pulse_time;
  logic [RATE_W-1:0]    smoothed_rate;
  logic [TIME_BITS-1:0] last_report_stamp;

  // Captured transaction and arithmetic registers.
  logic [SAMPLE_BITS-1:0] sample;
  logic [TIME_BITS-1:0]   now;
  logic [ACC_W-1:0]       acc;

  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LVL_W-1:0]     scaled;
  logic [LVL_W:0]       threshold;
  logic                 rise;
  logic                 fall;
  logic [TIME_BITS-1:0] interval;
  logic [TIME_BITS-1:0] elapsed;
  logic                 report_due;
  logic [MUL_B_W-1:0]   base_inv;
  logic [MUL_B_W-1:0]   rate_inv;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [ACC_W-1:0]     product;
  logic [ACC_W-1:0]     round_const;
  logic                 div_start;
  logic                 div_done;
  logic [RATE_W-1:0]    div_quotient;
  logic                 out_load;
  logic [RATE_W:0]      bpm_round;
  logic [RATE_W-FRAC_W:0] bpm_full;
  logic [BPM_W-1:0]     bpm_sat;

  // Configuration port decode.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = paddr[4:2];

  always_comb begin
    case (cfg_index)
      REG_BASELINE_START:  prdata = 32'(baseline_start);
      REG_RISE_MARGIN:     prdata = 32'(rise_margin);
      REG_REPORT_PERIOD:   prdata = 32'(report_period_us);
      REG_BASELINE_WEIGHT: prdata = 32'(baseline_weight);
      REG_RATE_WEIGHT:     prdata = 32'(rate_weight);
      default:             prdata = '0;
    endcase
  end

  // Pulse and report decisions on the updated baseline.
  assign scaled     = LVL_W'({sample, {FRAC_W{1'b0}}});
  assign threshold  = (LVL_W+1)'(baseline_level) + (LVL_W+1)'({rise_margin, {FRAC_W{1'b0}}});
  assign rise       = !in_pulse && ((LVL_W+1)'(scaled) > threshold);
  assign fall       = in_pulse && (scaled < baseline_level);
  assign interval   = now - prior_pulse_time;
  assign elapsed    = now - last_report_stamp;
  assign report_due = elapsed > TIME_BITS'(report_period_us);

  // Shared multiplier; weights of old values are 1 - w in Q1.16.
  assign base_inv    = (MUL_B_W'(1) << WEIGHT_W) - MUL_B_W'(baseline_weight);
  assign rate_inv    = (MUL_B_W'(1) << WEIGHT_W) - MUL_B_W'(rate_weight);
  assign product     = ACC_W'(mul_a) * ACC_W'(mul_b);
  assign round_const = ACC_W'(1) << (BLEND_SHIFT - 1);

  // Reported rate: round Q16.8 to an integer and saturate to 16 bits.
  assign bpm_round = (RATE_W+1)'(smoothed_rate) + (RATE_W+1)'(1 << (FRAC_W - 1));
  assign bpm_full  = bpm_round[RATE_W:FRAC_W];
  assign bpm_sat   = (bpm_full > (RATE_W-FRAC_W+1)'({BPM_W{1'b1}})) ?
                     {BPM_W{1'b1}} : bpm_full[BPM_W-1:0];

  // Sequencer: next state and operand selection.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_BASE_MUL0;
      end
      S_BASE_MUL0: begin
        mul_a      = MUL_A_W'(baseline_level);
        mul_b      = base_inv;
        state_next = S_BASE_MUL1;
      end
      S_BASE_MUL1: begin
        mul_a      = MUL_A_W'(scaled);
        mul_b      = MUL_B_W'(baseline_weight);
        state_next = S_BASE_UPD;
      end
      S_BASE_UPD: begin
        state_next = S_DETECT;
      end
      S_DETECT: begin
        if (rise && have_prior_pulse && (interval != '0)) begin
          div_start  = 1'b1;
          state_next = S_DIV_WAIT;
        end else begin
          state_next = S_REPORT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) state_next = S_RATE_MUL0;
      end
      S_RATE_MUL0: begin
        mul_a      = MUL_A_W'(smoothed_rate);
        mul_b      = rate_inv;
        state_next = S_RATE_MUL1;
      end
      S_RATE_MUL1: begin
        mul_a      = MUL_A_W'(div_quotient);
        mul_b      = MUL_B_W'(rate_weight);
        state_next = S_RATE_UPD;
      end
      S_RATE_UPD: begin
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (!report_due) begin
          state_next = S_IDLE;
        end else if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration and detector state.
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_start    <= BASELINE_START_RST;
      rise_margin       <= RISE_MARGIN_RST;
      report_period_us  <= REPORT_PERIOD_RST;
      baseline_weight   <= BASELINE_WEIGHT_RST;
      rate_weight       <= RATE_WEIGHT_RST;
      baseline_level    <= LVL_W'({BASELINE_START_RST, {FRAC_W{1'b0}}});
      in_pulse          <= 1'b0;
      have_prior_pulse  <= 1'b0;
      prior_pulse_time  <= '0;
      smoothed_rate     <= '0;
      last_report_stamp <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BASELINE_START: begin
            baseline_start <= pwdata[LEVEL_CFG_W-1:0];
            baseline_level <= LVL_W'({pwdata[LEVEL_CFG_W-1:0], {FRAC_W{1'b0}}});
          end
          REG_RISE_MARGIN:     rise_margin      <= pwdata[LEVEL_CFG_W-1:0];
          REG_REPORT_PERIOD:   report_period_us <= pwdata[PERIOD_W-1:0];
          REG_BASELINE_WEIGHT: baseline_weight  <= pwdata[WEIGHT_W-1:0];
          REG_RATE_WEIGHT:     rate_weight      <= pwdata[WEIGHT_W-1:0];
          default: begin
          end
        endcase
      end
      case (state)
        S_BASE_UPD: begin
          baseline_level <= LVL_W'(acc >> BLEND_SHIFT);
        end
        S_DETECT: begin
          if (rise) begin
            in_pulse         <= 1'b1;
            prior_pulse_time <= now;
            have_prior_pulse <= 1'b1;
          end else if (fall) begin
            in_pulse <= 1'b0;
          end
        end
        S_RATE_UPD: begin
          smoothed_rate <= RATE_W'(acc >> BLEND_SHIFT);
        end
        S_REPORT: begin
          if (out_load) last_report_stamp <= now;
        end
        default: begin
        end
      endcase
    end
  end

  // Captured transaction and multiply-accumulate register.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      sample <= sample_value;
      now    <= sample_time_us;
    end
    if (state inside {S_BASE_MUL0, S_RATE_MUL0}) begin
      acc <= round_const + product;
    end else if (state inside {S_BASE_MUL1, S_RATE_MUL1}) begin
      acc <= acc + product;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rate_bpm     <= bpm_sat;
      pulse_active <= in_pulse;
    end
  end

  // Beat interval to rate conversion.
  prd_rate_div #(
    .TIME_BITS (TIME_BITS)
  ) u_rate_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (interval),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule
